@@ sv/cva_pkg.sv @@
// cva_pkg: shared constants and types of the complex vector averager
// used by complex_vector_averager, its checker and the testbench files, no other dependencies
`timescale 1ns / 1ps

package cva_pkg;

  localparam int MAX_LEN_DEF     = 1024;
  localparam int MAX_VECTORS_DEF = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TDATA_W_DEF     = ((2 * SAMPLE_BITS_DEF + 7) / 8) * 8;

  // bit-serial divider control
  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

endpackage

@@ sv/complex_vector_averager.sv @@
// complex_vector_averager: coherent averaging of a set of complex vectors
// depends on cva_pkg; holds the accumulator memory, the per-set control and the divider
`timescale 1ns / 1ps

// Samples of a set of vectors enter on in_*; the first vector sets the length and
// writes the per-index accumulators, later vectors add into them through a read / write-back
// pipeline with forwarding, so items of non-final vectors are taken one per cycle while the
// divider is idle. Each item of the final vector (in_tuser high) leaves one result:
// (accumulator + sample) / vector count, truncated toward zero, through a bit-serial
// divider that retires one quotient bit a cycle for both parts at once. Such an item
// holds in_tready low until its result is loaded into the output register. A length
// mismatch or too many vectors flags the set; its final results then carry out_tuser
// high and zero data. The accumulator memory has no reset and no clearing pass; the
// block takes items right after reset.
module complex_vector_averager
  import cva_pkg::*;
#(
  parameter int  MAX_LEN     = MAX_LEN_DEF,
  parameter int  MAX_VECTORS = MAX_VECTORS_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // sample_re, sample_im, zero pad
  input  logic               in_tlast,   // end_of_vector
  input  logic               in_tuser,   // final_vector
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // avg_re, avg_im, zero pad
  output logic               out_tlast,  // last
  output logic               out_tuser   // error
);

  localparam int IDX_BITS  = $clog2(MAX_LEN + 1);
  localparam int ADDR_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int VC_BITS   = $clog2(MAX_VECTORS + 1);
  localparam int DVS_BITS  = VC_BITS + 1;
  localparam int ACC_BITS  = SAMPLE_BITS + $clog2(MAX_VECTORS);
  localparam int CNT_BITS  = $clog2(ACC_BITS + 1);
  localparam logic [ACC_BITS-1:0] MAX_MAG =
    ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  // set control
  logic [IDX_BITS-1:0] ref_len_r, ref_len_nxt;
  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  logic [VC_BITS-1:0]  vc_r, vc_nxt;
  logic                flag_r, flag_nxt;

  logic signed [SAMPLE_BITS-1:0] s_re, s_im;
  logic                accept, first, idx_ok, len_ok, vc_ok, ok, eov_bad, flag_upd;
  logic [IDX_BITS:0]   len;
  logic [ADDR_BITS-1:0] addr;

  // accumulator memory, {im, re}
  logic [2*ACC_BITS-1:0] acc_mem [MAX_LEN];
  logic [2*ACC_BITS-1:0] rd_r, last_sum_r, acc_val;

  // write-back stage
  logic                          s1_valid_r, s1_ok_r, s1_first_r, s1_fin_r, s1_eov_r;
  logic                          s1_err_r, s1_fwd_r;
  logic [ADDR_BITS-1:0]          s1_addr_r;
  logic signed [SAMPLE_BITS-1:0] s1_re_r, s1_im_r;
  logic [DVS_BITS-1:0]           s1_dvs_r;
  logic signed [ACC_BITS-1:0]    sum_re, sum_im;

  // divider, lane 0 real, lane 1 imaginary
  div_state_t                    div_state_r, div_state_nxt;
  logic [1:0][ACC_BITS-1:0]      q_r, q_nxt;
  logic [1:0][DVS_BITS-1:0]      rem_r, rem_nxt;
  logic [1:0]                    neg_r;
  logic [DVS_BITS-1:0]           dvs_r;
  logic [CNT_BITS-1:0]           cnt_r;
  logic                          d_err_r, d_last_r;
  logic [1:0][SAMPLE_BITS-1:0]   res;
  logic [1:0][ACC_BITS-1:0]      neg_q;
  logic [DVS_BITS:0]             trial;
  logic                          out_free, load_out;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] avg_re_r, avg_im_r;
  logic                   last_r, err_r;

  assign s_re   = in_tdata[SAMPLE_BITS-1:0];
  assign s_im   = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign accept = in_tvalid && in_tready;
  assign in_tready = rst_n && !(s1_valid_r && s1_fin_r) && (div_state_r == DIV_IDLE);

  assign first    = (vc_r == '0);
  assign idx_ok   = idx_r < IDX_BITS'(MAX_LEN);
  assign len_ok   = first || (idx_r < ref_len_r);
  assign vc_ok    = vc_r < VC_BITS'(MAX_VECTORS);
  assign ok       = idx_ok && len_ok && vc_ok;
  assign len      = {1'b0, idx_r} + (IDX_BITS+1)'(1);
  assign eov_bad  = in_tlast && (first ? !idx_ok : (len != {1'b0, ref_len_r}));
  assign flag_upd = flag_r || !ok || eov_bad;
  assign addr     = idx_r[ADDR_BITS-1:0];

  always_comb begin
    ref_len_nxt = ref_len_r;
    idx_nxt     = idx_r;
    vc_nxt      = vc_r;
    flag_nxt    = flag_r;
    if (accept) begin
      flag_nxt = flag_upd;
      if (in_tlast) begin
        idx_nxt = '0;
        if (first) begin
          ref_len_nxt = idx_ok ? len[IDX_BITS-1:0] : IDX_BITS'(MAX_LEN);
        end
        if (in_tuser) begin
          vc_nxt   = '0;
          flag_nxt = 1'b0;
        end else if (vc_ok) begin
          vc_nxt = vc_r + VC_BITS'(1);
        end
      end else if (idx_ok) begin
        idx_nxt = idx_r + IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r  <= '0;
      idx_r      <= '0;
      vc_r       <= '0;
      flag_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      ref_len_r  <= ref_len_nxt;
      idx_r      <= idx_nxt;
      vc_r       <= vc_nxt;
      flag_r     <= flag_nxt;
      s1_valid_r <= accept;
    end
  end

  // the item in write-back may target the entry read now, which then returns stale data
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r    <= ok;
      s1_first_r <= first;
      s1_fin_r   <= in_tuser;
      s1_eov_r   <= in_tlast;
      s1_err_r   <= flag_upd;
      s1_fwd_r   <= s1_valid_r && s1_ok_r && (s1_addr_r == addr);
      s1_addr_r  <= addr;
      s1_re_r    <= s_re;
      s1_im_r    <= s_im;
      s1_dvs_r   <= DVS_BITS'(vc_r) + DVS_BITS'(1);
      rd_r       <= acc_mem[addr];
    end
    if (s1_valid_r) begin
      last_sum_r <= {sum_im, sum_re};
      if (s1_ok_r) begin
        acc_mem[s1_addr_r] <= {sum_im, sum_re};
      end
    end
  end

  assign acc_val = s1_fwd_r ? last_sum_r : rd_r;

  always_comb begin
    sum_re = ACC_BITS'(s1_re_r);
    sum_im = ACC_BITS'(s1_im_r);
    if (!s1_first_r) begin
      sum_re = sum_re + $signed(acc_val[ACC_BITS-1:0]);
      sum_im = sum_im + $signed(acc_val[2*ACC_BITS-1:ACC_BITS]);
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign load_out = (div_state_r == DIV_DONE) && out_free;

  // one quotient bit per cycle, restoring
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_r[k], q_r[k][ACC_BITS-1]};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt[k] = DVS_BITS'(trial - {1'b0, dvs_r});
        q_nxt[k]   = {q_r[k][ACC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[DVS_BITS-1:0];
        q_nxt[k]   = {q_r[k][ACC_BITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    div_state_nxt = div_state_r;
    case (div_state_r)
      DIV_IDLE: if (s1_valid_r && s1_fin_r) div_state_nxt = DIV_RUN;
      DIV_RUN:  if (cnt_r == CNT_BITS'(1)) div_state_nxt = DIV_DONE;
      DIV_DONE: if (out_free) div_state_nxt = DIV_IDLE;
      default:  div_state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_IDLE;
    end else begin
      div_state_r <= div_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((div_state_r == DIV_IDLE) && s1_valid_r && s1_fin_r) begin
      neg_r    <= {sum_im[ACC_BITS-1], sum_re[ACC_BITS-1]};
      q_r[0]   <= sum_re[ACC_BITS-1] ? ACC_BITS'(-sum_re) : ACC_BITS'(sum_re);
      q_r[1]   <= sum_im[ACC_BITS-1] ? ACC_BITS'(-sum_im) : ACC_BITS'(sum_im);
      rem_r    <= '0;
      dvs_r    <= s1_dvs_r;
      cnt_r    <= CNT_BITS'(ACC_BITS);
      d_err_r  <= s1_err_r;
      d_last_r <= s1_eov_r;
    end else if (div_state_r == DIV_RUN) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  // sign, saturation and error zeroing of the quotients
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      neg_q[k] = ~q_r[k] + ACC_BITS'(1);
      if (d_err_r) begin
        res[k] = '0;
      end else if (neg_r[k]) begin
        if (q_r[k] > MAX_MAG + ACC_BITS'(1)) begin
          res[k] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
          res[k] = neg_q[k][SAMPLE_BITS-1:0];
        end
      end else if (q_r[k] > MAX_MAG) begin
        res[k] = MAX_MAG[SAMPLE_BITS-1:0];
      end else begin
        res[k] = q_r[k][SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      avg_re_r <= res[0];
      avg_im_r <= res[1];
      last_r   <= d_last_r;
      err_r    <= d_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({avg_im_r, avg_re_r});
  assign out_tlast  = last_r;
  assign out_tuser  = err_r;

endmodule

@@ sv/cva_checker.sv @@
// cva_checker: port-level assertions for complex_vector_averager
// depends on cva_pkg; bound into complex_vector_averager at the end of this file
`timescale 1ns / 1ps

module cva_checker
  import cva_pkg::*;
#(
  parameter int TDATA_W = TDATA_W_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               in_tuser,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast,
  input logic               out_tuser
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a flagged set gives zero averages
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result with nonzero data");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an item of the final vector occupies the divider
  a_fin_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("item taken behind a final-vector item");

endmodule

bind complex_vector_averager cva_checker #(.TDATA_W(TDATA_W)) u_cva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

@@ tb/cva_avg_monitor.sv @@
// cva_avg_monitor: watches both streams of complex_vector_averager, folds each
// accepted sample into its own copy of the accumulators and checks every average
// depends on cva_pkg for the stream widths and the block's size limits
`timescale 1ns / 1ps

module cva_avg_monitor
  import cva_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [TDATA_W_DEF-1:0] in_tdata,   // sample_re, sample_im
  input  logic                   in_tlast,   // end_of_vector
  input  logic                   in_tuser,   // final_vector
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [TDATA_W_DEF-1:0] out_tdata,  // avg_re, avg_im
  input  logic                   out_tlast,  // last
  input  logic                   out_tuser,  // error
  output int                     fail_count,
  output int                     pending
);

  localparam int SMAX = (1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
  localparam int SMIN = -SMAX - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] re;
    logic signed [SAMPLE_BITS_DEF-1:0] im;
    logic                              last;
    logic                              err;
  } avg_item_t;

  logic signed [23:0] sum_store_re [MAX_LEN_DEF];
  logic signed [23:0] sum_store_im [MAX_LEN_DEF];
  logic [10:0]        vec_len;
  logic [10:0]        pos;
  logic [8:0]         vec_seen;
  logic               set_bad;
  avg_item_t          expected_avgs [$];
  avg_item_t          want;

  function automatic logic signed [SAMPLE_BITS_DEF-1:0] avg_of(input int sum, input int n);
    int q;
    q = sum / n;
    if (q > SMAX) q = SMAX;
    if (q < SMIN) q = SMIN;
    return q[SAMPLE_BITS_DEF-1:0];
  endfunction

  task automatic fold_sample(input logic signed [SAMPLE_BITS_DEF-1:0] s_re,
                             input logic signed [SAMPLE_BITS_DEF-1:0] s_im,
                             input logic eov, input logic fin);
    int        idx;
    int        sum_re;
    int        sum_im;
    bit        first;
    bit        ok;
    int        len;
    avg_item_t r;
    idx    = pos;
    first  = (vec_seen == 0);
    ok     = 1'b1;
    sum_re = s_re;
    sum_im = s_im;
    if (idx >= MAX_LEN_DEF) ok = 1'b0;
    if (!first && idx >= vec_len) ok = 1'b0;
    if (vec_seen >= MAX_VECTORS_DEF) ok = 1'b0;
    if (!ok) set_bad = 1'b1;
    if (ok) begin
      if (!first) begin
        sum_re += sum_store_re[idx];
        sum_im += sum_store_im[idx];
      end
      sum_store_re[idx] = sum_re[23:0];
      sum_store_im[idx] = sum_im[23:0];
    end
    if (eov) begin
      len = idx + 1;
      if (first) begin
        vec_len = 11'((len > MAX_LEN_DEF) ? MAX_LEN_DEF : len);
        if (len > MAX_LEN_DEF) set_bad = 1'b1;
      end else if (len != vec_len) begin
        set_bad = 1'b1;
      end
    end
    if (fin) begin
      r.err  = set_bad;
      r.last = eov;
      r.re   = set_bad ? '0 : avg_of(sum_re, int'(vec_seen) + 1);
      r.im   = set_bad ? '0 : avg_of(sum_im, int'(vec_seen) + 1);
      expected_avgs = {expected_avgs, r};
    end
    if (eov) begin
      pos = '0;
      if (fin) begin
        vec_seen = '0;
        set_bad  = 1'b0;
      end else if (vec_seen < MAX_VECTORS_DEF) begin
        vec_seen = vec_seen + 1'b1;
      end
    end else if (pos < MAX_LEN_DEF) begin
      pos = pos + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      vec_len    = '0;
      pos        = '0;
      vec_seen   = '0;
      set_bad    = 1'b0;
      fail_count = 0;
      expected_avgs.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_avgs.size() == 0) begin
          $error("result item with no average pending: avg_re %0d avg_im %0d",
                 $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
          fail_count++;
        end else begin
          want = expected_avgs.pop_front();
          if (out_tdata[15:0] !== want.re) begin
            $error("avg_re mismatch: expected %0d, actual %0d",
                   want.re, $signed(out_tdata[15:0]));
            fail_count++;
          end
          if (out_tdata[31:16] !== want.im) begin
            $error("avg_im mismatch: expected %0d, actual %0d",
                   want.im, $signed(out_tdata[31:16]));
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_tlast);
            fail_count++;
          end
          if (out_tuser !== want.err) begin
            $error("error mismatch: expected %0d, actual %0d", want.err, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        fold_sample(in_tdata[15:0], in_tdata[31:16], in_tlast, in_tuser);
    end
    pending = expected_avgs.size();
  end

endmodule

@@ tb/tb_complex_vector_averager.sv @@
// tb_complex_vector_averager: drives sets of complex vectors into the averager,
// stalls the result side at random and gives the verdict
// depends on cva_pkg, complex_vector_averager and cva_avg_monitor
`timescale 1ns / 1ps

module tb_complex_vector_averager;
  import cva_pkg::*;

  localparam int SMAX       = (1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
  localparam int SMIN       = -SMAX - 1;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_OFF   = 400;
  localparam int TAIL       = 100;

  // sample styles of a vector
  localparam int STYLE_RANDOM  = 0;
  localparam int STYLE_EXTREME = 1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [TDATA_W_DEF-1:0] in_tdata;   // sample_re, sample_im
  logic                   in_tlast;   // end_of_vector
  logic                   in_tuser;   // final_vector
  logic                   out_tvalid;
  logic                   out_tready;
  logic [TDATA_W_DEF-1:0] out_tdata;  // avg_re, avg_im
  logic                   out_tlast;  // last
  logic                   out_tuser;  // error
  int                     fail_count;
  int                     pending;
  int                     idle_cycles;
  int                     items_sent;
  int                     tx_burst;

  complex_vector_averager DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  cva_avg_monitor avg_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // runs of zero-wait items now and then, otherwise a random wait before each item
  function automatic int next_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [SAMPLE_BITS_DEF-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SMIN[SAMPLE_BITS_DEF-1:0];
      1:       return SMAX[SAMPLE_BITS_DEF-1:0];
      2:       return SAMPLE_BITS_DEF'(int'($urandom_range(0, 7)) - 4);
      default: return SAMPLE_BITS_DEF'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [SAMPLE_BITS_DEF-1:0] re,
                           input logic [SAMPLE_BITS_DEF-1:0] im,
                           input logic eov, input logic fin);
    int gap;
    gap = next_gap(tx_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {im, re};
    in_tlast  <= eov;
    in_tuser  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_vector(input int len, input bit fin, input int style);
    for (int i = 0; i < len; i++) begin
      if (style == STYLE_EXTREME)
        send_item(SMIN[SAMPLE_BITS_DEF-1:0], SMAX[SAMPLE_BITS_DEF-1:0], i == len - 1, fin);
      else
        send_item(rand_sample(), rand_sample(), i == len - 1, fin);
    end
  endtask

  // bad_vec < 0 keeps every vector at len
  task automatic send_set(input int n_vec, input int len, input int bad_vec,
                          input int bad_len, input int style);
    for (int v = 0; v < n_vec; v++)
      send_vector((v == bad_vec) ? bad_len : len, v == n_vec - 1, style);
  endtask

  task automatic run_directed();
    // one-vector sets give their samples back
    send_item(16'sh7fff, 16'sh8000, 1'b1, 1'b1);
    send_item(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
    send_item(16'sh0000, 16'sh0000, 1'b0, 1'b1);
    send_item(16'shffff, 16'sh0001, 1'b1, 1'b1);
    // two vectors at full scale
    send_item(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
    send_item(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_item(16'sh7fff, 16'sh8000, 1'b0, 1'b1);
    send_item(16'sh8000, 16'sh7fff, 1'b1, 1'b1);
    // truncation toward zero: -5/3 and 2/3
    send_item(16'shfffe, 16'sh0001, 1'b1, 1'b0);
    send_item(16'shfffe, 16'sh0001, 1'b1, 1'b0);
    send_item(16'shffff, 16'sh0000, 1'b1, 1'b1);
    // later vector shorter than the first
    send_item(16'sh0100, 16'sh0200, 1'b0, 1'b0);
    send_item(16'sh0300, 16'sh0400, 1'b1, 1'b0);
    send_item(16'sh0500, 16'sh0600, 1'b1, 1'b0);
    send_item(16'sh0700, 16'sh0800, 1'b0, 1'b1);
    send_item(16'sh0900, 16'sh0a00, 1'b1, 1'b1);
    // later vector longer than the first
    send_item(16'sh1234, 16'sh4321, 1'b1, 1'b0);
    send_item(16'sh1111, 16'sh2222, 1'b0, 1'b0);
    send_item(16'sh3333, 16'sh4444, 1'b1, 1'b0);
    send_item(16'sh5555, 16'sh6666, 1'b1, 1'b1);
    // final vector ends early
    send_item(16'sh0010, 16'sh0020, 1'b0, 1'b0);
    send_item(16'sh0030, 16'sh0040, 1'b1, 1'b0);
    send_item(16'sh0050, 16'sh0060, 1'b1, 1'b1);
  endtask

  task automatic run_general(input int count);
    int start;
    int kind;
    int n_vec;
    int len;
    int bad_vec;
    int bad_len;
    int n;
    start = items_sent;
    while (items_sent - start < count) begin
      kind  = $urandom_range(0, 99);
      n_vec = $urandom_range(1, 8);
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      if (kind < 75) begin
        send_set(n_vec, len, -1, 0, STYLE_RANDOM);
      end else if (kind < 90) begin
        n_vec   = $urandom_range(2, 8);
        bad_vec = $urandom_range(1, n_vec - 1);
        do bad_len = len + $urandom_range(0, 6) - 3;
        while (bad_len < 1 || bad_len == len);
        send_set(n_vec, len, bad_vec, bad_len, STYLE_RANDOM);
      end else begin
        // loose flags, then a closing item ends whatever set was left open
        n = $urandom_range(1, 20);
        repeat (n)
          send_item(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        send_item(rand_sample(), rand_sample(), 1'b1, 1'b1);
      end
    end
  endtask

  task automatic run_random();
    run_general(80);
    // the largest legal set, every sum at the edge of the accumulator range
    send_set(MAX_VECTORS_DEF, 1, -1, 0, STYLE_EXTREME);
    run_general(80);
    // two vectors past the limit, count saturates
    send_set(MAX_VECTORS_DEF + 2, 1, -1, 0, STYLE_RANDOM);
    run_general(80);
    run_general(50);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : result_sink
    int hold;
    int rx_count;
    int rx_burst;
    out_tready = 1'b0;
    rx_count   = 0;
    rx_burst   = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      // long hold-offs let the block back up into its input
      if (rx_count == 30 || rx_count == 120)
        hold = HOLD_OFF;
      else
        hold = next_gap(rx_burst);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      rx_count++;
      @(negedge clk);
    end
  end

  initial begin
    items_sent  = 0;
    tx_burst    = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    in_tuser    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
